// ----- rtl/core/selt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the shared/exclusive lock table: request and result types,
// mode and status codes, default sizes. No dependencies.
package selt_pkg;

  localparam int PAGES_DEFAULT      = 1024;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int MODE_W    = 3;
  localparam int INDEX_W   = 10;
  localparam int STATUS_W  = 2;
  localparam int READERS_W = 16;

  // request modes
  localparam logic [MODE_W-1:0] MODE_SHARED    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXCLUSIVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RECLAIM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNLOCK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UPGRADE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DOWNGRADE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DELETED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISUSE  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] page_index;
    logic               page_free;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 wake;
    logic [READERS_W-1:0] readers;
    logic                 held_exclusive;
    logic                 is_deleted;
  } res_t;

endpackage

// ----- rtl/core/shared_exclusive_lock_table.sv -----
`timescale 1ns / 1ps
// Top level of the shared/exclusive lock table.
// Depends on selt_pkg and selt_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  request | in        | req_valid / req_ready | req (selt_pkg::req_t)
//  result  | out       | res_valid / res_ready | res (selt_pkg::res_t)
//
// One request a cycle sustained while results are taken; each request is taken
// as the lock table is read into the RAM read register and the update stage,
// then the update loads the output register, from which the result is taken.
// The lock table memory read and the write-back of the previous request
// overlap; a write to the same entry in the read cycle is forwarded.
// After reset a clearing pass writes every entry unlocked, with req_ready
// low. A stalled result holds the update stage; the request side then
// stalls too.
module shared_exclusive_lock_table #(
  parameter int PAGES      = selt_pkg::PAGES_DEFAULT,
  parameter int COUNT_BITS = selt_pkg::COUNT_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  selt_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output selt_pkg::res_t res
);

  import selt_pkg::*;

  localparam int ADDR_W = $clog2(PAGES);
  localparam int WORD_W = COUNT_BITS + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(PAGES - 1);

  // lock word layout: {deleted, exclusive, reader count}
  typedef struct packed {
    logic                  del;
    logic                  ex;
    logic [COUNT_BITS-1:0] cnt;
  } lock_word_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] clr_addr;

  // update stage: request whose lock word is being read
  logic              s1_valid;
  logic [MODE_W-1:0] s1_mode;
  logic              s1_free;
  logic              s1_in_range;
  logic [ADDR_W-1:0] s1_addr;
  logic              byp;
  lock_word_t        byp_word;

  logic              accept;
  logic              s1_adv;
  logic              req_in_range;
  logic [ADDR_W-1:0] req_addr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  lock_word_t        wr_data;
  logic [WORD_W-1:0] rd_data;

  lock_word_t        cur;
  lock_word_t        upd;
  logic [MODE_W-1:0] eff_mode;
  logic [STATUS_W-1:0] status;
  logic              wake;

  assign req_in_range = 32'(req.page_index) < PAGES;
  assign req_addr     = ADDR_W'(req.page_index);

  // Advance the update stage when the output register is free or draining.
  assign s1_adv    = s1_valid && (!res_valid || res_ready);
  assign req_ready = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign accept    = req_valid && req_ready;

  // Clearing pass owns the write port; otherwise write back the update.
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = s1_adv && s1_in_range;
      wr_addr = s1_addr;
      wr_data = upd;
    end
  end

  selt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PAGES)
  ) u_lock_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(req_addr),
    .rd_data(rd_data)
  );

  // Take the forwarded word when the previous request wrote this entry
  // in the same cycle as the read.
  assign cur = byp ? byp_word : lock_word_t'(rd_data);

  // Lock update for one request.
  always_comb begin
    upd    = cur;
    status = STATUS_OK;
    wake   = 1'b0;
    if (s1_mode == MODE_RECLAIM) begin
      eff_mode = s1_free ? MODE_EXCLUSIVE : MODE_SHARED;
    end else begin
      eff_mode = s1_mode;
    end
    case (eff_mode)
      MODE_SHARED: begin
        if (cur.del) begin
          status = STATUS_DELETED;
        end else if (cur.ex || cur.cnt == COUNT_MAX) begin
          status = STATUS_BUSY;
        end else begin
          upd.cnt = cur.cnt + COUNT_ONE;
        end
      end
      MODE_EXCLUSIVE: begin
        if (cur.del) begin
          status = STATUS_DELETED;
        end else if (cur.ex || cur.cnt != '0) begin
          status = STATUS_BUSY;
        end else begin
          upd.ex = 1'b1;
        end
      end
      MODE_UNLOCK: begin
        if (cur.del) begin
          status = STATUS_MISUSE;
        end else if (cur.ex) begin
          upd.ex = 1'b0;
          wake   = 1'b1;
        end else if (cur.cnt == COUNT_ONE) begin
          upd.cnt = '0;
          wake    = 1'b1;
        end else if (cur.cnt != '0) begin
          upd.cnt = cur.cnt - COUNT_ONE;
        end else begin
          status = STATUS_MISUSE;
        end
      end
      MODE_UPGRADE: begin
        if (cur.del) begin
          status = STATUS_DELETED;
        end else if (cur.ex || cur.cnt == '0) begin
          status = STATUS_MISUSE;
        end else if (cur.cnt == COUNT_ONE) begin
          upd.cnt = '0;
          upd.ex  = 1'b1;
        end else begin
          status = STATUS_BUSY;
        end
      end
      MODE_DOWNGRADE: begin
        if (cur.del) begin
          status = STATUS_DELETED;
        end else if (!cur.ex) begin
          status = STATUS_MISUSE;
        end else begin
          upd.ex  = 1'b0;
          upd.cnt = COUNT_ONE;
          wake    = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (cur.del) begin
          status = STATUS_DELETED;
        end else if (!cur.ex) begin
          status = STATUS_MISUSE;
        end else begin
          upd.ex  = 1'b0;
          upd.del = 1'b1;
          upd.cnt = '0;
          wake    = 1'b1;
        end
      end
      default: begin
        status = STATUS_MISUSE;
      end
    endcase
  end

  // State, clearing counter, update stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= ST_RUN;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      // hold the request while its lock word is read
      if (accept) begin
        s1_valid    <= 1'b1;
        s1_mode     <= req.mode;
        s1_free     <= req.page_free;
        s1_in_range <= req_in_range;
        s1_addr     <= req_addr;
        byp         <= wr_en && (wr_addr == req_addr);
        byp_word    <= wr_data;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      // load the result, or drop it once taken
      if (s1_adv) begin
        res_valid <= 1'b1;
        if (s1_in_range) begin
          res.status         <= status;
          res.wake           <= wake;
          res.readers        <= READERS_W'(upd.cnt);
          res.held_exclusive <= upd.ex;
          res.is_deleted     <= upd.del;
        end else begin
          res.status         <= STATUS_MISUSE;
          res.wake           <= 1'b0;
          res.readers        <= '0;
          res.held_exclusive <= 1'b0;
          res.is_deleted     <= 1'b0;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/selt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module selt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
